FILE: sv/hgm_pkg.sv
// Package for the handshake gesture matcher: constants, register indexes,
// micro-operation and jump-condition codes, and the microcode table.
// Depends on nothing; imported by handshake_gesture_matcher.
package hgm_pkg;

   // Pitch limits used while tracking the extremes of a device.
   localparam logic [7:0] LIMIT_MAX = 8'd130;
   localparam logic [7:0] LIMIT_MIN = 8'd50;
   localparam logic [7:0] MIN_RESET = 8'd180;

   // Register reset values.
   localparam logic [3:0] RST_ACTIVE_DEVICES  = 4'd2;
   localparam logic [7:0] RST_GATE_LOW        = 8'd60;
   localparam logic [7:0] RST_GATE_HIGH       = 8'd120;
   localparam logic [7:0] RST_QUALIFY_COUNT   = 8'd25;
   localparam logic [7:0] RST_WINDOW_OPEN     = 8'd50;
   localparam logic [7:0] RST_WINDOW_CLOSE    = 8'd200;
   localparam logic [7:0] RST_MATCH_TOLERANCE = 8'd20;
   localparam logic [7:0] RST_MIN_SWING       = 8'd15;

   // Register indexes on the control port.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type REG_ACTIVE_DEVICES  = 3'd0;
   localparam csr_index_type REG_GATE_LOW        = 3'd1;
   localparam csr_index_type REG_GATE_HIGH       = 3'd2;
   localparam csr_index_type REG_QUALIFY_COUNT   = 3'd3;
   localparam csr_index_type REG_WINDOW_OPEN     = 3'd4;
   localparam csr_index_type REG_WINDOW_CLOSE    = 3'd5;
   localparam csr_index_type REG_MATCH_TOLERANCE = 3'd6;
   localparam csr_index_type REG_MIN_SWING       = 3'd7;

   // Request kinds.
   localparam logic KIND_SAMPLE   = 1'b0;
   localparam logic KIND_EVALUATE = 1'b1;

   // Micro-operations.
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP      = 4'd0;
   localparam op_type OP_GATE     = 4'd1;
   localparam op_type OP_SET_ANA  = 4'd2;
   localparam op_type OP_EXTREMES = 4'd3;
   localparam op_type OP_SWING    = 4'd4;
   localparam op_type OP_INC_X    = 4'd5;
   localparam op_type OP_CLEAR    = 4'd6;
   localparam op_type OP_EMIT     = 4'd7;
   localparam op_type OP_INC_CNT  = 4'd8;
   localparam op_type OP_STORE    = 4'd9;

   // Jump conditions.
   typedef logic [3:0] cond_type;
   localparam cond_type C_NEVER      = 4'd0;
   localparam cond_type C_ALWAYS     = 4'd1;
   localparam cond_type C_NO_REQ     = 4'd2;
   localparam cond_type C_BAD_DEV    = 4'd3;
   localparam cond_type C_SAMPLE     = 4'd4;
   localparam cond_type C_INACTIVE   = 4'd5;
   localparam cond_type C_ANALYSING  = 4'd6;
   localparam cond_type C_QUALIFIED  = 4'd7;
   localparam cond_type C_NOT_WINDOW = 4'd8;
   localparam cond_type C_SCAN_DONE  = 4'd9;
   localparam cond_type C_HIT        = 4'd10;
   localparam cond_type C_NOT_CLOSE  = 4'd11;
   localparam cond_type C_RSP_BUSY   = 4'd12;

   // Program steps.
   typedef logic [4:0] step_type;
   localparam step_type STEP_IDLE      = 5'd0;
   localparam step_type STEP_DISPATCH  = 5'd1;
   localparam step_type STEP_KIND      = 5'd2;
   localparam step_type STEP_ACTIVE    = 5'd3;
   localparam step_type STEP_MODE      = 5'd4;
   localparam step_type STEP_QUALIFY   = 5'd5;
   localparam step_type STEP_GATE      = 5'd6;
   localparam step_type STEP_ENTER     = 5'd7;
   localparam step_type STEP_ANALYSE   = 5'd8;
   localparam step_type STEP_SWING     = 5'd9;
   localparam step_type STEP_WINDOW    = 5'd10;
   localparam step_type STEP_SCAN      = 5'd11;
   localparam step_type STEP_TEST      = 5'd12;
   localparam step_type STEP_NEXT      = 5'd13;
   localparam step_type STEP_CLOSE     = 5'd14;
   localparam step_type STEP_CLOSE_CLR = 5'd15;
   localparam step_type STEP_MATCH     = 5'd16;
   localparam step_type STEP_MATCH_OWN = 5'd17;
   localparam step_type STEP_EMIT      = 5'd18;
   localparam step_type STEP_TAIL      = 5'd19;
   localparam step_type STEP_STORE     = 5'd20;

   typedef struct packed {
      op_type   op;
      logic     sel_x;   // address the scanned partner instead of the own device
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type cw(input op_type op, input logic sel_x,
                                        input cond_type cond, input step_type target);
      ctrl_word_type w;
      w.op     = op;
      w.sel_x  = sel_x;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // The microprogram. A step falls through to the next one unless its
   // condition holds, in which case it jumps to its target.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:      w = cw(OP_NOP,      1'b0, C_NO_REQ,     STEP_IDLE);
         STEP_DISPATCH:  w = cw(OP_NOP,      1'b0, C_BAD_DEV,    STEP_IDLE);
         STEP_KIND:      w = cw(OP_NOP,      1'b0, C_SAMPLE,     STEP_STORE);
         STEP_ACTIVE:    w = cw(OP_NOP,      1'b0, C_INACTIVE,   STEP_IDLE);
         STEP_MODE:      w = cw(OP_NOP,      1'b0, C_ANALYSING,  STEP_ANALYSE);
         STEP_QUALIFY:   w = cw(OP_NOP,      1'b0, C_QUALIFIED,  STEP_ENTER);
         STEP_GATE:      w = cw(OP_GATE,     1'b0, C_ALWAYS,     STEP_IDLE);
         STEP_ENTER:     w = cw(OP_SET_ANA,  1'b0, C_NEVER,      STEP_IDLE);
         STEP_ANALYSE:   w = cw(OP_EXTREMES, 1'b0, C_NEVER,      STEP_IDLE);
         STEP_SWING:     w = cw(OP_SWING,    1'b0, C_NEVER,      STEP_IDLE);
         STEP_WINDOW:    w = cw(OP_NOP,      1'b0, C_NOT_WINDOW, STEP_CLOSE);
         STEP_SCAN:      w = cw(OP_NOP,      1'b0, C_SCAN_DONE,  STEP_TAIL);
         STEP_TEST:      w = cw(OP_NOP,      1'b1, C_HIT,        STEP_MATCH);
         STEP_NEXT:      w = cw(OP_INC_X,    1'b0, C_ALWAYS,     STEP_SCAN);
         STEP_CLOSE:     w = cw(OP_NOP,      1'b0, C_NOT_CLOSE,  STEP_TAIL);
         STEP_CLOSE_CLR: w = cw(OP_CLEAR,    1'b0, C_ALWAYS,     STEP_TAIL);
         STEP_MATCH:     w = cw(OP_CLEAR,    1'b1, C_NEVER,      STEP_IDLE);
         STEP_MATCH_OWN: w = cw(OP_CLEAR,    1'b0, C_NEVER,      STEP_IDLE);
         STEP_EMIT:      w = cw(OP_EMIT,     1'b0, C_RSP_BUSY,   STEP_EMIT);
         STEP_TAIL:      w = cw(OP_INC_CNT,  1'b0, C_ALWAYS,     STEP_IDLE);
         STEP_STORE:     w = cw(OP_STORE,    1'b0, C_ALWAYS,     STEP_IDLE);
         default:        w = cw(OP_NOP,      1'b0, C_ALWAYS,     STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

FILE: sv/handshake_gesture_matcher.sv
// A sample request stores pitch and fist; an evaluate request for a device not taking part
// changes nothing. Outside analysis an evaluate gates the counter, or enters analysis once
// qualified. In analysis it updates extremes and swing and, inside the match window, scans
// every active index for a partner; a match clears both and waits for the result register.
// Throughput: one request at a time, set by the sequencer; a result waits in its register.
// Reset (synchronous, active high) restores control, step, result-valid and device state.
module handshake_gesture_matcher
   import hgm_pkg::*;
#(
   parameter int MAX_DEVICES = 8
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [2:0] req_device,
   input  logic [7:0] req_pitch,
   input  logic       req_fist,
   // Result channel.
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_first_device,
   output logic [2:0] rsp_second_device,
   // Control register write port.
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // Index width for the per-device state and counter width for the partner
   // scan, which must also hold the device count itself.
   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int CNT_W = $clog2(MAX_DEVICES + 1);

   // Control registers.
   logic [3:0] active_devices_ff;
   logic [7:0] gate_low_ff, gate_high_ff, qualify_count_ff;
   logic [7:0] window_open_ff, window_close_ff, match_tolerance_ff, min_swing_ff;

   // Per-device state, kept in flip-flops and read at one sequencer address.
   logic [7:0] last_pitch_ff [MAX_DEVICES];
   logic [7:0] last_pitch_in [MAX_DEVICES];
   logic       is_fist_ff    [MAX_DEVICES];
   logic       is_fist_in    [MAX_DEVICES];
   logic [7:0] counter_ff    [MAX_DEVICES];
   logic [7:0] counter_in    [MAX_DEVICES];
   logic       analysing_ff  [MAX_DEVICES];
   logic       analysing_in  [MAX_DEVICES];
   logic [7:0] pitch_max_ff  [MAX_DEVICES];
   logic [7:0] pitch_max_in  [MAX_DEVICES];
   logic [7:0] pitch_min_ff  [MAX_DEVICES];
   logic [7:0] pitch_min_in  [MAX_DEVICES];
   logic [8:0] swing_ff      [MAX_DEVICES];
   logic [8:0] swing_in      [MAX_DEVICES];

   // Sequencer and working registers.
   step_type   step_ff, step_in;
   logic       kind_ff, kind_in;
   logic [2:0] dev_ff, dev_in;
   logic [7:0] pitch_ff, pitch_in;
   logic       fist_ff, fist_in;
   logic [CNT_W-1:0] x_ff, x_in;
   logic       own_win_ff, own_win_in;
   logic [8:0] own_swing_ff, own_swing_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_first_ff, rsp_first_in;
   logic [2:0] rsp_second_ff, rsp_second_in;

   ctrl_word_type    ucw;
   logic [IDX_W-1:0] addr;
   logic             accept;
   logic             rsp_busy;
   logic             jump;
   logic [7:0]       dev_ext, x_ext, count_ext;

   // Values read at the current address.
   logic [7:0] rd_pitch, rd_counter, rd_max, rd_min;
   logic       rd_fist, rd_analysing;
   logic [8:0] rd_swing;
   logic       rd_in_window;
   logic [7:0] new_max, new_min;
   logic [8:0] new_swing;

   // Partner comparison.
   logic signed [10:0] swing_diff, tol_s;
   logic               swing_ok, hit;

   assign ucw = ucode_rom(step_ff);

   assign req_ready         = (step_ff == STEP_IDLE);
   assign accept            = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_device  = rsp_first_ff;
   assign rsp_second_device = rsp_second_ff;
   assign rsp_busy          = rsp_valid_ff && !rsp_ready;

   // Active count, capped at the number of devices that exist.
   assign dev_ext   = 8'(dev_ff);
   assign x_ext     = 8'(x_ff);
   assign count_ext = (8'(active_devices_ff) > 8'(MAX_DEVICES)) ? 8'(MAX_DEVICES)
                                                               : 8'(active_devices_ff);

   // Every read of per-device state goes through this single address.
   assign addr = ucw.sel_x ? IDX_W'(x_ff) : IDX_W'(dev_ff);

   assign rd_pitch     = last_pitch_ff[addr];
   assign rd_fist      = is_fist_ff[addr];
   assign rd_counter   = counter_ff[addr];
   assign rd_analysing = analysing_ff[addr];
   assign rd_max       = pitch_max_ff[addr];
   assign rd_min       = pitch_min_ff[addr];
   assign rd_swing     = swing_ff[addr];
   assign rd_in_window = (rd_counter > window_open_ff) && (rd_counter < window_close_ff)
                         && rd_fist;

   // Extremes: the first analysis step after a clear loads both with the
   // current pitch; later steps only widen them within the fixed limits.
   always_comb begin
      new_max = rd_max;
      new_min = rd_min;
      if (rd_max == 8'd0 && rd_min == MIN_RESET) begin
         new_max = rd_pitch;
         new_min = rd_pitch;
      end else begin
         if (rd_max < rd_pitch && rd_pitch < LIMIT_MAX) begin
            new_max = rd_pitch;
         end
         if (rd_min > rd_pitch && rd_pitch > LIMIT_MIN) begin
            new_min = rd_pitch;
         end
      end
   end

   assign new_swing = (rd_max >= rd_min) ? 9'(rd_max - rd_min) : 9'd0;

   // A partner matches when it is another device in its window, the two swings differ by
   // less than the tolerance and the own swing is above the minimum.
   assign swing_diff = $signed({2'b00, own_swing_ff}) - $signed({2'b00, rd_swing});
   assign tol_s      = $signed({3'b000, match_tolerance_ff});
   assign swing_ok   = (swing_diff > -tol_s) && (swing_diff < tol_s)
                       && ({1'b0, min_swing_ff} < own_swing_ff);
   assign hit        = (x_ext != dev_ext) && rd_in_window && swing_ok;

   // Jump condition of the current control word.
   always_comb begin
      unique case (ucw.cond)
         C_NEVER:      jump = 1'b0;
         C_ALWAYS:     jump = 1'b1;
         C_NO_REQ:     jump = !req_valid;
         C_BAD_DEV:    jump = dev_ext >= 8'(MAX_DEVICES);
         C_SAMPLE:     jump = (kind_ff == KIND_SAMPLE);
         C_INACTIVE:   jump = dev_ext >= count_ext;
         C_ANALYSING:  jump = rd_analysing;
         C_QUALIFIED:  jump = rd_counter >= qualify_count_ff;
         C_NOT_WINDOW: jump = !own_win_ff;
         C_SCAN_DONE:  jump = x_ext >= count_ext;
         C_HIT:        jump = hit;
         C_NOT_CLOSE:  jump = (rd_counter != window_close_ff);
         C_RSP_BUSY:   jump = rsp_busy;
         default:      jump = 1'b0;
      endcase
   end

   // Datapath driven by the micro-operation of the current step.
   always_comb begin
      step_in       = jump ? ucw.target : step_ff + 5'd1;
      kind_in       = kind_ff;
      dev_in        = dev_ff;
      pitch_in      = pitch_ff;
      fist_in       = fist_ff;
      x_in          = x_ff;
      own_win_in    = own_win_ff;
      own_swing_in  = own_swing_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      last_pitch_in = last_pitch_ff;
      is_fist_in    = is_fist_ff;
      counter_in    = counter_ff;
      analysing_in  = analysing_ff;
      pitch_max_in  = pitch_max_ff;
      pitch_min_in  = pitch_min_ff;
      swing_in      = swing_ff;

      if (accept) begin
         kind_in  = req_kind;
         dev_in   = req_device;
         pitch_in = req_pitch;
         fist_in  = req_fist;
      end

      case (ucw.op)
         OP_GATE: begin
            if (rd_pitch > gate_low_ff && rd_pitch < gate_high_ff) begin
               counter_in[addr] = rd_counter + 8'd1;
            end else begin
               counter_in[addr] = 8'd0;
            end
         end
         OP_SET_ANA: begin
            analysing_in[addr] = 1'b1;
         end
         OP_EXTREMES: begin
            pitch_max_in[addr] = new_max;
            pitch_min_in[addr] = new_min;
         end
         OP_SWING: begin
            swing_in[addr] = new_swing;
            own_swing_in   = new_swing;
            own_win_in     = rd_in_window;
            x_in           = '0;
         end
         OP_INC_X: begin
            x_in = x_ff + CNT_W'(1);
         end
         OP_CLEAR: begin
            pitch_max_in[addr] = 8'd0;
            pitch_min_in[addr] = MIN_RESET;
            swing_in[addr]     = 9'd0;
            analysing_in[addr] = 1'b0;
            counter_in[addr]   = 8'd0;
         end
         OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = dev_ff;
               rsp_second_in = 3'(x_ff);
            end
         end
         OP_INC_CNT: begin
            // The counter advances after every analysis step, even after a clear.
            counter_in[addr] = rd_counter + 8'd1;
         end
         OP_STORE: begin
            last_pitch_in[addr] = pitch_ff;
            is_fist_in[addr]    = fist_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_devices_ff  <= RST_ACTIVE_DEVICES;
         gate_low_ff        <= RST_GATE_LOW;
         gate_high_ff       <= RST_GATE_HIGH;
         qualify_count_ff   <= RST_QUALIFY_COUNT;
         window_open_ff     <= RST_WINDOW_OPEN;
         window_close_ff    <= RST_WINDOW_CLOSE;
         match_tolerance_ff <= RST_MATCH_TOLERANCE;
         min_swing_ff       <= RST_MIN_SWING;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_ACTIVE_DEVICES:  active_devices_ff  <= csr_wdata[3:0];
            REG_GATE_LOW:        gate_low_ff        <= csr_wdata;
            REG_GATE_HIGH:       gate_high_ff       <= csr_wdata;
            REG_QUALIFY_COUNT:   qualify_count_ff   <= csr_wdata;
            REG_WINDOW_OPEN:     window_open_ff     <= csr_wdata;
            REG_WINDOW_CLOSE:    window_close_ff    <= csr_wdata;
            REG_MATCH_TOLERANCE: match_tolerance_ff <= csr_wdata;
            REG_MIN_SWING:       min_swing_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer, result register and per-device state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DEVICES; i++) begin
            last_pitch_ff[i] <= 8'd0;
            is_fist_ff[i]    <= 1'b0;
            counter_ff[i]    <= 8'd0;
            analysing_ff[i]  <= 1'b0;
            pitch_max_ff[i]  <= 8'd0;
            pitch_min_ff[i]  <= MIN_RESET;
            swing_ff[i]      <= 9'd0;
         end
      end else begin
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_pitch_ff <= last_pitch_in;
         is_fist_ff    <= is_fist_in;
         counter_ff    <= counter_in;
         analysing_ff  <= analysing_in;
         pitch_max_ff  <= pitch_max_in;
         pitch_min_ff  <= pitch_min_in;
         swing_ff      <= swing_in;
      end
   end

   // Working and payload registers need no reset.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      dev_ff        <= dev_in;
      pitch_ff      <= pitch_in;
      fist_ff       <= fist_in;
      x_ff          <= x_in;
      own_win_ff    <= own_win_in;
      own_swing_ff  <= own_swing_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for handshake_gesture_matcher: random and directed requests,
// a per-device predictor held in a small scoreboard class, and an in-order result check.
// Depends on hgm_pkg and handshake_gesture_matcher.
`timescale 1ns / 1ps

module tb_top;
   import hgm_pkg::*;

   localparam int NUM_DEVICES   = 8;
   // Comfortably covers the slowest request (a full partner scan plus the result
   // hand-over), so a request still in flight can finish.
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [2:0] first_dev;
      logic [2:0] second_dev;
   } handshake_pair_type;

   // Predicts the pairs that the matcher reports and checks them in order.
   // It keeps its own copy of the control registers and of every device's state.
   class match_scoreboard;
      logic [3:0] n_active;
      logic [7:0] gate_lo, gate_hi, qualify_len, win_open, win_close, tolerance, swing_floor;
      logic [7:0] last_pitch [NUM_DEVICES];
      bit         fisted     [NUM_DEVICES];
      logic [7:0] counter    [NUM_DEVICES];
      bit         analysing  [NUM_DEVICES];
      logic [7:0] pitch_hi   [NUM_DEVICES];
      logic [7:0] pitch_lo   [NUM_DEVICES];
      logic [8:0] swing      [NUM_DEVICES];
      handshake_pair_type pairs_due [$];
      int n_errors, n_pairs, n_requests, n_evaluations;

      function new();
         n_active    = RST_ACTIVE_DEVICES;
         gate_lo     = RST_GATE_LOW;
         gate_hi     = RST_GATE_HIGH;
         qualify_len = RST_QUALIFY_COUNT;
         win_open    = RST_WINDOW_OPEN;
         win_close   = RST_WINDOW_CLOSE;
         tolerance   = RST_MATCH_TOLERANCE;
         swing_floor = RST_MIN_SWING;
         for (int d = 0; d < NUM_DEVICES; d++) begin
            last_pitch[d] = '0;
            fisted[d]     = 1'b0;
            clear_device(d);
         end
      endfunction

      function void clear_device(int d);
         pitch_hi[d]  = '0;
         pitch_lo[d]  = MIN_RESET;
         swing[d]     = '0;
         analysing[d] = 1'b0;
         counter[d]   = '0;
      endfunction

      function bit in_window(int d);
         return counter[d] > win_open && counter[d] < win_close && fisted[d];
      endfunction

      function int pending();
         return pairs_due.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            REG_ACTIVE_DEVICES:  n_active    = value[3:0];
            REG_GATE_LOW:        gate_lo     = value;
            REG_GATE_HIGH:       gate_hi     = value;
            REG_QUALIFY_COUNT:   qualify_len = value;
            REG_WINDOW_OPEN:     win_open    = value;
            REG_WINDOW_CLOSE:    win_close   = value;
            REG_MATCH_TOLERANCE: tolerance   = value;
            REG_MIN_SWING:       swing_floor = value;
            default: ;
         endcase
      endfunction

      // Advances the predicted state for one accepted request.
      function void note_request(logic kind, logic [2:0] dev, logic [7:0] pitch, logic fist);
         int span, partner, s, t, tol;
         logic [7:0] p;
         handshake_pair_type pair;
         n_requests++;
         span = (n_active > NUM_DEVICES) ? NUM_DEVICES : int'(n_active);
         if (kind == KIND_SAMPLE) begin
            last_pitch[dev] = pitch;
            fisted[dev]     = fist;
            return;
         end
         n_evaluations++;
         if (int'(dev) >= span) return;
         if (!analysing[dev]) begin
            if (counter[dev] >= qualify_len) begin
               analysing[dev] = 1'b1;
            end else begin
               if (last_pitch[dev] > gate_lo && last_pitch[dev] < gate_hi)
                  counter[dev] = counter[dev] + 8'd1;
               else
                  counter[dev] = '0;
               return;
            end
         end
         p = last_pitch[dev];
         if (pitch_hi[dev] == 0 && pitch_lo[dev] == MIN_RESET) begin
            pitch_hi[dev] = p;
            pitch_lo[dev] = p;
         end else begin
            if (pitch_hi[dev] < p && p < LIMIT_MAX) pitch_hi[dev] = p;
            if (pitch_lo[dev] > p && p > LIMIT_MIN) pitch_lo[dev] = p;
         end
         swing[dev] = (pitch_hi[dev] >= pitch_lo[dev]) ?
                      {1'b0, pitch_hi[dev] - pitch_lo[dev]} : '0;
         partner = -1;
         if (in_window(dev)) begin
            for (int x = 0; x < span; x++) begin
               if (x == int'(dev) || !in_window(x)) continue;
               s   = int'(swing[dev]);
               t   = int'(swing[x]);
               tol = int'(tolerance);
               if (s > t - tol && s < t + tol && s > int'(swing_floor)) begin
                  clear_device(dev);
                  clear_device(x);
                  partner = x;
                  break;
               end
            end
         end else if (counter[dev] == win_close) begin
            clear_device(dev);
         end
         counter[dev] = counter[dev] + 8'd1;
         if (partner >= 0) begin
            pair.first_dev  = dev;
            pair.second_dev = partner[2:0];
            pairs_due = {pairs_due, pair};
            n_pairs++;
         end
      endfunction

      // Compares one reported pair with the oldest prediction.
      function void check_result(logic [2:0] first_dev, logic [2:0] second_dev);
         handshake_pair_type want;
         if (pairs_due.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected handshake, expected none, got %0d-%0d",
                     $time, first_dev, second_dev);
            return;
         end
         want = pairs_due.pop_front();
         if (want.first_dev !== first_dev) begin
            n_errors++;
            $display("%0t: first_device mismatch, expected %0d, got %0d",
                     $time, want.first_dev, first_dev);
         end
         if (want.second_dev !== second_dev) begin
            n_errors++;
            $display("%0t: second_device mismatch, expected %0d, got %0d",
                     $time, want.second_dev, second_dev);
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_ready;
   logic          req_kind     = KIND_SAMPLE;
   logic [2:0]    req_device   = '0;
   logic [7:0]    req_pitch    = '0;
   logic          req_fist     = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready    = 1'b0;
   logic [2:0]    rsp_first_device;
   logic [2:0]    rsp_second_device;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index    = REG_ACTIVE_DEVICES;
   logic [7:0]    csr_wdata    = '0;

   // Idling, in per cent of cycles, for each side of the block. The run starts
   // with a lazy receiver.
   int send_idle_pct = 6;
   int recv_idle_pct = 55;
   int n_settings    = 0;

   match_scoreboard sb = new();

   handshake_gesture_matcher #(.MAX_DEVICES(NUM_DEVICES)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_device        (req_device),
      .req_pitch         (req_pitch),
      .req_fist          (req_fist),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_first_device  (rsp_first_device),
      .rsp_second_device (rsp_second_device),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random. Its ready is updated at the clock edge, so
   // the value seen at an edge is always the one held during the cycle before.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Every result taken by the receiver is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_first_device, rsp_second_device);
      end
   end

   // Offers one request and returns at the edge at which it is accepted. Valid is
   // only lowered when the sender decides to idle, so back-to-back requests keep
   // it high without a second assignment in the same time step.
   task automatic send_request(input logic kind, input logic [2:0] dev,
                               input logic [7:0] pitch, input logic fist);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_device <= dev;
      req_pitch  <= pitch;
      req_fist   <= fist;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, dev, pitch, fist);
   endtask

   // Lets the block run dry: no request offered, every predicted pair delivered,
   // then enough cycles for a request that produces no result to finish.
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sb.pending() > 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // Writes all eight control registers; only called while the block is idle.
   task automatic set_config(input logic [7:0] n_act, gl, gh, qc, wo, wc, tol, ms);
      put_reg(REG_ACTIVE_DEVICES,  n_act);
      put_reg(REG_GATE_LOW,        gl);
      put_reg(REG_GATE_HIGH,       gh);
      put_reg(REG_QUALIFY_COUNT,   qc);
      put_reg(REG_WINDOW_OPEN,     wo);
      put_reg(REG_WINDOW_CLOSE,    wc);
      put_reg(REG_MATCH_TOLERANCE, tol);
      put_reg(REG_MIN_SWING,       ms);
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   // One random request. Most requests address a taking-part device and follow
   // its predicted state: pitches inside the gate while it qualifies, and swinging
   // pitches with a mostly closed fist once it is in analysis, so that devices do
   // reach the match window. About one in ten is pure noise over every field.
   task automatic send_shaped_request();
      int         span;
      logic [2:0] dev;
      logic [7:0] pitch;
      span = (sb.n_active > NUM_DEVICES) ? NUM_DEVICES : int'(sb.n_active);
      if (span == 0 || $urandom_range(0, 99) < 10) begin
         send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         return;
      end
      dev = 3'($urandom_range(0, span - 1));
      if ($urandom_range(0, 2) != 0) begin
         send_request(KIND_EVALUATE, dev, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      end else if (!sb.analysing[dev]) begin
         if (int'(sb.gate_hi) > int'(sb.gate_lo) + 1)
            pitch = 8'($urandom_range(int'(sb.gate_lo) + 1, int'(sb.gate_hi) - 1));
         else
            pitch = 8'($urandom_range(0, 180));
         send_request(KIND_SAMPLE, dev, pitch, 1'($urandom_range(0, 1)));
      end else begin
         send_request(KIND_SAMPLE, dev, 8'($urandom_range(40, 140)),
                      $urandom_range(0, 3) != 0);
      end
   endtask

   // Runs a stretch of random requests.
   task automatic run_random(input int n_items);
      for (int sent = 0; sent < n_items; sent++) begin
         send_shaped_request();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset settings: a zero pitch outside the gate,
      // a device beyond the taking-part range with a pitch of 255, the top of the
      // field range, and a pitch of 180, equal to the minimum's reset value.
      send_request(KIND_SAMPLE,   3'd0, 8'd0,   1'b0);
      send_request(KIND_EVALUATE, 3'd0, 8'd0,   1'b0);
      send_request(KIND_SAMPLE,   3'd7, 8'd255, 1'b1);
      send_request(KIND_EVALUATE, 3'd7, 8'd255, 1'b1);
      send_request(KIND_SAMPLE,   3'd1, 8'd180, 1'b1);
      send_request(KIND_EVALUATE, 3'd1, 8'd0,   1'b0);
      drain();

      // Three devices, quick qualification and a short window. Devices 0 and 1
      // both build a swing of 20, which stays under the minimum swing of 22, so
      // neither pairs. Device 2 then reaches a swing of 25 and finds both of them
      // in tolerance; only the lower-indexed one, device 0, may be reported.
      // Device 1 then steps once more with devices 0 and 2 already cleared.
      set_config(8'd3, 8'd60, 8'd120, 8'd1, 8'd0, 8'd10, 8'd20, 8'd22);
      send_request(KIND_SAMPLE,   3'd0, 8'd90,  1'b1);
      send_request(KIND_EVALUATE, 3'd0, 8'd0,   1'b0);
      send_request(KIND_EVALUATE, 3'd0, 8'd0,   1'b0);
      send_request(KIND_SAMPLE,   3'd1, 8'd90,  1'b1);
      send_request(KIND_EVALUATE, 3'd1, 8'd0,   1'b0);
      send_request(KIND_EVALUATE, 3'd1, 8'd0,   1'b0);
      send_request(KIND_SAMPLE,   3'd2, 8'd95,  1'b1);
      send_request(KIND_EVALUATE, 3'd2, 8'd0,   1'b0);
      send_request(KIND_EVALUATE, 3'd2, 8'd0,   1'b0);
      send_request(KIND_SAMPLE,   3'd0, 8'd70,  1'b1);
      send_request(KIND_EVALUATE, 3'd0, 8'd0,   1'b0);
      send_request(KIND_SAMPLE,   3'd1, 8'd110, 1'b1);
      send_request(KIND_EVALUATE, 3'd1, 8'd0,   1'b0);
      send_request(KIND_SAMPLE,   3'd2, 8'd120, 1'b1);
      send_request(KIND_EVALUATE, 3'd2, 8'd0,   1'b0);
      send_request(KIND_EVALUATE, 3'd1, 8'd0,   1'b0);
      drain();

      // Random part, first with a lazy receiver. Two devices and a generous
      // window give frequent handshakes.
      send_idle_pct = 6;
      recv_idle_pct = 55;
      set_config(8'd2, 8'd60, 8'd120, 8'd3, 8'd2, 8'd40, 8'd20, 8'd15);
      run_random(500);
      drain();

      // Now a lazy sender. An active count above the number of devices acts as
      // all eight; a wide tolerance and no minimum swing pair almost anything.
      send_idle_pct = 55;
      recv_idle_pct = 6;
      set_config(8'd15, 8'd0, 8'd180, 8'd1, 8'd0, 8'd25, 8'd180, 8'd0);
      run_random(300);
      drain();

      // A single device with zero tolerance and a minimum swing of 180 can
      // never pair; the window only closes at the very top of the counter.
      set_config(8'd1, 8'd50, 8'd130, 8'd2, 8'd0, 8'd255, 8'd0, 8'd180);
      run_random(150);
      drain();

      // No idling from here on. An active count of zero disables evaluation, and
      // an inverted gate could never qualify a pitch anyway.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'd0, 8'd180, 8'd0, 8'd1, 8'd0, 8'd1, 8'd20, 8'd15);
      run_random(60);
      drain();

      // Counter wrap: analysis only starts at 255 and the window can never open,
      // so the counter rolls over through zero until it meets the close value.
      set_config(8'd2, 8'd0, 8'd180, 8'd255, 8'd255, 8'd1, 8'd20, 8'd15);
      run_random(700);
      drain();

      $display("Ran %0d requests (%0d evaluations) over %0d register settings plus reset.",
               sb.n_requests, sb.n_evaluations, n_settings);
      $display("Predicted %0d handshakes; %0d mismatches found.", sb.n_pairs, sb.n_errors);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected handshakes never arrived", $time, sb.pending());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #10_000_000;
      $display("%0t: run limit reached, %0d handshakes still outstanding",
               $time, sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
